// ===== rtl/gost_feistel_block_cipher_defines.svh =====
// assertion macros for the gost feistel block cipher
`ifndef GOST_FEISTEL_BLOCK_CIPHER_DEFINES_SVH
`define GOST_FEISTEL_BLOCK_CIPHER_DEFINES_SVH

`ifndef ASSERT_OFF
`define GFB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GFB_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GFB_ASSERT(lbl, clk, rst_n, prop, msg)
`define GFB_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/gfb_pkg.sv =====
// types, s-box table and round function of the gost feistel block cipher
package gfb_pkg;

    localparam int unsigned NumRounds = 32;
    localparam int unsigned NumKeys   = 8;
    localparam int unsigned RotAmount = 11;

    typedef logic [NumKeys-1:0][31:0] t_key;

    typedef struct packed {
        logic        valid;
        logic        dec;
        logic [31:0] a;
        logic [31:0] b;
    } t_stage;

    localparam logic [3:0] SBOX [0:7][0:15] = '{
        '{4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9,
          4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1},
        '{4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12,
          4'd1, 4'd14, 4'd4, 4'd7, 4'd11, 4'd13, 4'd0, 4'd15},
        '{4'd11, 4'd3, 4'd5, 4'd8, 4'd2, 4'd15, 4'd10, 4'd13,
          4'd14, 4'd1, 4'd7, 4'd4, 4'd12, 4'd9, 4'd6, 4'd0},
        '{4'd12, 4'd8, 4'd2, 4'd1, 4'd13, 4'd4, 4'd15, 4'd6,
          4'd7, 4'd0, 4'd10, 4'd5, 4'd3, 4'd14, 4'd9, 4'd11},
        '{4'd7, 4'd15, 4'd5, 4'd10, 4'd8, 4'd1, 4'd6, 4'd13,
          4'd0, 4'd9, 4'd3, 4'd14, 4'd11, 4'd4, 4'd2, 4'd12},
        '{4'd5, 4'd13, 4'd15, 4'd6, 4'd9, 4'd2, 4'd12, 4'd10,
          4'd11, 4'd7, 4'd8, 4'd1, 4'd4, 4'd3, 4'd14, 4'd0},
        '{4'd8, 4'd14, 4'd2, 4'd5, 4'd6, 4'd9, 4'd1, 4'd12,
          4'd15, 4'd4, 4'd11, 4'd0, 4'd13, 4'd10, 4'd3, 4'd7},
        '{4'd1, 4'd7, 4'd14, 4'd13, 4'd0, 4'd5, 4'd8, 4'd3,
          4'd4, 4'd15, 4'd10, 4'd6, 4'd9, 4'd12, 4'd11, 4'd2}
    };

    // encryption schedule: words 0..7 three times, then 7..0
    function automatic logic [2:0] key_index(input logic [4:0] rnd);
        logic [2:0] idx;
        if (rnd[4:3] != 2'b11) begin
            idx = rnd[2:0];
        end else begin
            idx = 3'd7 - rnd[2:0];
        end
        return idx;
    endfunction

    function automatic logic [31:0] round_fn(input logic [31:0] half,
                                             input logic [31:0] subkey);
        logic [31:0] sum;
        logic [31:0] sub;
        sum = half + subkey;
        for (int i = 0; i < 8; i++) begin
            sub[31-4*i -: 4] = SBOX[i][sum[31-4*i -: 4]];
        end
        return {sub[31-RotAmount:0], sub[31:32-RotAmount]};
    endfunction

endpackage

// ===== rtl/gfb_round_cell.sv =====
// one feistel round cell with its pipeline register
module gfb_round_cell #(
    parameter int unsigned ROUND = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gfb_pkg::t_key   i_key,
    input  gfb_pkg::t_stage i_stage,
    output gfb_pkg::t_stage o_stage
);

    localparam logic [4:0] RndEnc = 5'(ROUND);
    localparam logic [4:0] RndDec = 5'(gfb_pkg::NumRounds - 1 - ROUND);

    logic [2:0]      w_kidx;
    logic [31:0]     w_subkey;
    gfb_pkg::t_stage n_stage;
    gfb_pkg::t_stage r_stage;

    always_comb begin
        w_kidx   = i_stage.dec ? gfb_pkg::key_index(RndDec) : gfb_pkg::key_index(RndEnc);
        w_subkey = i_key[w_kidx];
        n_stage.valid = i_stage.valid;
        n_stage.dec   = i_stage.dec;
        n_stage.a     = i_stage.b ^ gfb_pkg::round_fn(i_stage.a, w_subkey);
        n_stage.b     = i_stage.a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= n_stage.valid;
        end
        r_stage.dec <= n_stage.dec;
        r_stage.a   <= n_stage.a;
        r_stage.b   <= n_stage.b;
    end

    assign o_stage = r_stage;

endmodule

// ===== rtl/gost_feistel_block_cipher.sv =====
// top level of the gost 28147-89 feistel block cipher
//
// usage:
//   key: write key words 0..7 through i_cfg_we / i_cfg_idx / i_cfg_data while
//   no block is in flight; indexes above 7 are ignored. all words reset to 0.
//   input: a transaction is taken at a clock edge with i_start high and
//   o_busy low; i_data_block and i_decrypt are sampled at that edge.
//   output: o_valid is high for one cycle with o_result_block, once the
//   block has passed through all 32 round cell registers.
//   throughput: one block per cycle while o_busy is low; each of the 32 round
//   cells holds one block and passes it to the next cell every cycle.
//   reset: synchronous, active low; clears the key, drops all blocks in
//   flight and holds o_busy high until the cycle after reset is released.
//   the receiver cannot stall; every result is shown for a single cycle.
`include "gost_feistel_block_cipher_defines.svh"

module gost_feistel_block_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_start,
    input  logic [63:0] i_data_block,
    input  logic        i_decrypt,
    output logic        o_busy,
    output logic        o_valid,
    output logic [63:0] o_result_block
);

    gfb_pkg::t_key   r_key;
    logic            r_rdy;
    logic            w_accept;
    gfb_pkg::t_stage w_chain [0:gfb_pkg::NumRounds];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
            r_rdy <= 1'b0;
        end else begin
            r_rdy <= 1'b1;
            if (i_cfg_we && !i_cfg_idx[3]) begin
                r_key[i_cfg_idx[2:0]] <= i_cfg_data;
            end
        end
    end

    assign o_busy   = !r_rdy;
    assign w_accept = i_start && r_rdy;

    always_comb begin
        w_chain[0].valid = w_accept;
        w_chain[0].dec   = i_decrypt;
        w_chain[0].a     = i_data_block[63:32];
        w_chain[0].b     = i_data_block[31:0];
    end

    for (genvar g = 0; g < gfb_pkg::NumRounds; g++) begin : g_cell
        gfb_round_cell #(
            .ROUND (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_key   (r_key),
            .i_stage (w_chain[g]),
            .o_stage (w_chain[g+1])
        );
    end

    assign o_valid        = w_chain[gfb_pkg::NumRounds].valid;
    assign o_result_block = {w_chain[gfb_pkg::NumRounds].b, w_chain[gfb_pkg::NumRounds].a};

    `GFB_ASSERT(a_latency, i_clk, i_rst_n, w_accept |-> ##32 o_valid, "result missing")
    `GFB_ASSERT(a_no_spurious, i_clk, i_rst_n, o_valid |-> $past(w_accept, 32), "spurious result")
    `GFB_ASSERT_NORST(a_reset_flush, i_clk, !i_rst_n |=> !o_valid && o_busy, "reset did not flush")

endmodule

// ===== sim/tb_gost_feistel_block_cipher.sv =====
// self-checking testbench for the gost feistel block cipher: key writes, directed and random blocks
module tb_gost_feistel_block_cipher;

    localparam int unsigned ItemsPerPhase = 100;
    localparam int unsigned NumPhases     = 6;
    localparam int unsigned DrainCycles   = 48;
    localparam int unsigned CycleLimit    = 200000;

    typedef struct packed {
        logic [63:0] blk;
        logic        dec;
    } t_block_req;

    localparam logic [3:0] SUBST [8][16] = '{
        '{4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9,
          4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1},
        '{4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12,
          4'd1, 4'd14, 4'd4, 4'd7, 4'd11, 4'd13, 4'd0, 4'd15},
        '{4'd11, 4'd3, 4'd5, 4'd8, 4'd2, 4'd15, 4'd10, 4'd13,
          4'd14, 4'd1, 4'd7, 4'd4, 4'd12, 4'd9, 4'd6, 4'd0},
        '{4'd12, 4'd8, 4'd2, 4'd1, 4'd13, 4'd4, 4'd15, 4'd6,
          4'd7, 4'd0, 4'd10, 4'd5, 4'd3, 4'd14, 4'd9, 4'd11},
        '{4'd7, 4'd15, 4'd5, 4'd10, 4'd8, 4'd1, 4'd6, 4'd13,
          4'd0, 4'd9, 4'd3, 4'd14, 4'd11, 4'd4, 4'd2, 4'd12},
        '{4'd5, 4'd13, 4'd15, 4'd6, 4'd9, 4'd2, 4'd12, 4'd10,
          4'd11, 4'd7, 4'd8, 4'd1, 4'd4, 4'd3, 4'd14, 4'd0},
        '{4'd8, 4'd14, 4'd2, 4'd5, 4'd6, 4'd9, 4'd1, 4'd12,
          4'd15, 4'd4, 4'd11, 4'd0, 4'd13, 4'd10, 4'd3, 4'd7},
        '{4'd1, 4'd7, 4'd14, 4'd13, 4'd0, 4'd5, 4'd8, 4'd3,
          4'd4, 4'd15, 4'd10, 4'd6, 4'd9, 4'd12, 4'd11, 4'd2}
    };

    localparam int unsigned NumDirected = 13;
    localparam t_block_req DIRECTED [NumDirected] = '{
        '{64'h0000_0000_0000_0000, 1'b0},
        '{64'h0000_0000_0000_0000, 1'b1},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1},
        '{64'h8000_0000_0000_0000, 1'b0},
        '{64'h0000_0000_0000_0001, 1'b1},
        '{64'h0000_0000_FFFF_FFFF, 1'b0},
        '{64'hFFFF_FFFF_0000_0000, 1'b1},
        '{64'h5555_5555_5555_5555, 1'b0},
        '{64'hAAAA_AAAA_AAAA_AAAA, 1'b1},
        '{64'h0123_4567_89AB_CDEF, 1'b0},
        '{64'hFEDC_BA98_7654_3210, 1'b1},
        '{64'h0000_0001_0000_0000, 1'b0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [3:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        i_start;
    logic [63:0] i_data_block;
    logic        i_decrypt;
    logic        o_busy;
    logic        o_valid;
    logic [63:0] o_result_block;

    logic [31:0] key_words [gfb_pkg::NumKeys];
    logic [63:0] pending_blocks [$];
    logic [63:0] want_block;
    int unsigned failures    = 0;
    int unsigned cycle_count = 0;

    gost_feistel_block_cipher dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_start        (i_start),
        .i_data_block   (i_data_block),
        .i_decrypt      (i_decrypt),
        .o_busy         (o_busy),
        .o_valid        (o_valid),
        .o_result_block (o_result_block)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // 32 feistel rounds with the current key copy
    function automatic logic [63:0] gost_transform(input logic [63:0] blk, input logic dec);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] sum;
        logic [31:0] sub;
        logic [31:0] mixed;
        logic [4:0]  step;
        logic [2:0]  kidx;
        a = blk[63:32];
        b = blk[31:0];
        for (int r = 0; r < gfb_pkg::NumRounds; r++) begin
            step = dec ? 5'(gfb_pkg::NumRounds - 1 - r) : 5'(r);
            kidx = (step < 5'd24) ? step[2:0] : 3'd7 - step[2:0];
            sum  = a + key_words[kidx];
            for (int n = 0; n < 8; n++) begin
                sub[31-4*n -: 4] = SUBST[n][sum[31-4*n -: 4]];
            end
            mixed = {sub[20:0], sub[31:21]} ^ b;
            b = a;
            a = mixed;
        end
        return {b, a};
    endfunction

    task automatic write_key(input logic [3:0] idx, input logic [31:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        if (idx < gfb_pkg::NumKeys) begin
            key_words[idx[2:0]] = value;
        end
    endtask

    task automatic send_block(input logic [63:0] blk, input logic dec,
                              input int unsigned idle_pct);
        bit lowered;
        lowered = 1'b0;
        while ($urandom_range(99) < idle_pct) begin
            if (!lowered) begin
                i_start <= 1'b0;
                lowered = 1'b1;
            end
            @(posedge i_clk);
        end
        i_start      <= 1'b1;
        i_data_block <= blk;
        i_decrypt    <= dec;
        do @(posedge i_clk); while (o_busy);
        pending_blocks = {pending_blocks, gost_transform(blk, dec)};
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("tb: failure");
            $finish;
        end else if (i_rst_n && o_valid) begin
            if (pending_blocks.size() == 0) begin
                $error("result_block: no transaction pending, actual %h", o_result_block);
                failures++;
            end else begin
                want_block = pending_blocks.pop_front();
                if (o_result_block !== want_block) begin
                    $error("result_block: expected %h, actual %h", want_block, o_result_block);
                    failures++;
                end
            end
        end
    end

    initial begin
        int unsigned idle_pct;
        int unsigned pct;
        int unsigned burst;
        logic [63:0] blk;
        logic        dec;
        logic [63:0] last_out;
        logic        last_dec;
        bit          have_last;
        logic [31:0] value;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        i_start      = 1'b0;
        i_data_block = '0;
        i_decrypt    = 1'b0;
        for (int k = 0; k < gfb_pkg::NumKeys; k++) begin
            key_words[k] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < NumPhases; p++) begin
            idle_pct = (p < 2) ? 38 : (p < 4) ? 77 : 0;
            while (pending_blocks.size() != 0) @(posedge i_clk);

            // writes above the last key word must be dropped
            write_key(4'($urandom_range(15, gfb_pkg::NumKeys)), $urandom);
            if (p != 0) begin
                for (int k = 0; k < gfb_pkg::NumKeys; k++) begin
                    case (p)
                        1:       value = '1;
                        2:       value = (k % 2 == 0) ? 32'h0 : 32'hFFFF_FFFF;
                        default: value = $urandom;
                    endcase
                    write_key(4'(k), value);
                end
            end
            i_cfg_we <= 1'b0;

            if (p == 0) begin
                for (int i = 0; i < NumDirected; i++) begin
                    send_block(DIRECTED[i].blk, DIRECTED[i].dec, idle_pct);
                end
            end

            burst     = 0;
            have_last = 1'b0;
            for (int n = 0; n < ItemsPerPhase; n++) begin
                if (burst == 0 && $urandom_range(19) == 0) begin
                    burst = $urandom_range(30, 10);
                end
                pct = (burst != 0) ? 0 : idle_pct;
                if (burst != 0) begin
                    burst--;
                end
                // round trip: feed the last output back in the other direction
                if (have_last && $urandom_range(3) == 0) begin
                    blk = last_out;
                    dec = ~last_dec;
                end else begin
                    case ($urandom_range(3))
                        0, 1:    blk = {$urandom, $urandom};
                        2:       blk = 64'h1 << $urandom_range(63);
                        default: blk = {($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0,
                                        $urandom};
                    endcase
                    dec = 1'($urandom_range(1));
                end
                send_block(blk, dec, pct);
                last_out  = pending_blocks[$];
                last_dec  = dec;
                have_last = 1'b1;
            end
            i_start <= 1'b0;
        end

        while (pending_blocks.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/gfb_pkg.sv
rtl/gfb_round_cell.sv
rtl/gost_feistel_block_cipher.sv
sim/tb_gost_feistel_block_cipher.sv
